// File: sv/ami_pkg.sv
// Package for the affine matrix inverse: widths, codes and item types.
package ami_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  localparam int PW   = 2 * DATA_WIDTH;
  localparam int AW   = 2 * DATA_WIDTH + 1;
  localparam int DETW = 3 * DATA_WIDTH + 1;
  localparam int SW   = DETW + 2;
  localparam int UW   = 4 * DATA_WIDTH + 2;
  localparam int QW   = DATA_WIDTH + 1;
  localparam int NDS  = DATA_WIDTH + 2;
  localparam int NLANE = 4;

  typedef logic [1:0] row_t;

  localparam row_t FIRST_ROW = 2'd0;
  localparam row_t LAST_ROW  = 2'd2;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] in_r0c0;
    logic signed [DATA_WIDTH-1:0] in_r0c1;
    logic signed [DATA_WIDTH-1:0] in_r0c2;
    logic signed [DATA_WIDTH-1:0] in_r0c3;
    logic signed [DATA_WIDTH-1:0] in_r1c0;
    logic signed [DATA_WIDTH-1:0] in_r1c1;
    logic signed [DATA_WIDTH-1:0] in_r1c2;
    logic signed [DATA_WIDTH-1:0] in_r1c3;
    logic signed [DATA_WIDTH-1:0] in_r2c0;
    logic signed [DATA_WIDTH-1:0] in_r2c1;
    logic signed [DATA_WIDTH-1:0] in_r2c2;
    logic signed [DATA_WIDTH-1:0] in_r2c3;
  } in_t;

  typedef struct packed {
    row_t                         row_index;
    logic signed [DATA_WIDTH-1:0] out_c0;
    logic signed [DATA_WIDTH-1:0] out_c1;
    logic signed [DATA_WIDTH-1:0] out_c2;
    logic signed [DATA_WIDTH-1:0] out_c3;
    logic                         singular;
    logic                         saturated;
    logic                         last_row;
  } out_t;

  typedef struct packed {
    row_t row;
    logic sing;
  } meta_t;

endpackage

// File: sv/ami_in_if.sv
// Input channel carrying one matrix item.
interface ami_in_if;
  logic           valid;
  logic           ready;
  ami_pkg::in_t   data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// File: sv/ami_out_if.sv
// Output channel carrying one inverse row item.
interface ami_out_if;
  logic           valid;
  logic           ready;
  ami_pkg::out_t  data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// File: sv/affine_matrix_inverse.sv
// Affine 4x4 matrix inverse by adjugate and exact fixed-point division.
//
// matrix: one item is the top three rows of [A | t], twelve signed Q16.16 entries.
// rows:   three items per matrix, rows 0, 1, 2 of [A^-1 | -A^-1 t] in that
//         order, last_row set on row 2, singular set (and entries zero) when
//         det(A) is zero, saturated set when an entry of the row was clamped.
// A row buffer splits each matrix into three rows, one per cycle while the
// pipeline is not stalled; the next matrix is taken as the last row of the
// previous one leaves the buffer, and while stalled only if the buffer is empty.
// Each row passes 6 arithmetic stages (cofactors, determinant, translation sum)
// and a 34-stage restoring divider (four lanes; stage 0 flags overflow, each
// later stage settles one quotient bit), then the output register;
// throughput is one row per cycle while rows.ready stays high.
// When rows.ready is low with a row waiting, the whole pipeline holds; nothing
// is lost or repeated.
// Reset (rst, synchronous) clears all valid bits and the row buffer's row counter.
module affine_matrix_inverse (
  input  logic      clk,
  input  logic      rst,
  ami_in_if.sink    matrix,
  ami_out_if.source rows
);
  import ami_pkg::*;

  localparam int DW = DATA_WIDTH;

  logic adv;
  logic vout;
  out_t odata;

  // row buffer, columns rotated so that column 0 holds column i of A
  logic               fv;
  row_t               cnt;
  logic signed [DW-1:0] rm [3][3];
  logic signed [DW-1:0] tv [3];

  // stage 1
  logic               s1v;
  row_t               s1row;
  logic signed [PW-1:0] s1p [3];
  logic signed [PW-1:0] s1q [3];
  logic signed [DW-1:0] s1ca [3];
  logic signed [DW-1:0] s1t [3];

  // stage 2
  logic               s2v;
  row_t               s2row;
  logic signed [AW-1:0] s2adj [3];
  logic signed [DW-1:0] s2ca [3];
  logic signed [DW-1:0] s2t [3];

  // stage 3
  logic               s3v;
  row_t               s3row;
  logic signed [AW-1:0] s3adj [3];
  logic signed [AW-1:0] s3dl [3];
  logic signed [AW-1:0] s3dh [3];
  logic signed [AW-1:0] s3nl [3];
  logic signed [AW-1:0] s3nh [3];

  // stage 4
  logic               s4v;
  row_t               s4row;
  logic signed [AW-1:0]   s4adj [3];
  logic signed [DETW-1:0] s4dp [3];
  logic signed [DETW-1:0] s4np [3];

  // stage 5
  logic               s5v;
  row_t               s5row;
  logic signed [AW-1:0] s5adj [3];
  logic signed [SW-1:0] s5det;
  logic signed [SW-1:0] s5nt;

  // divider pipeline; index 0 is loaded by stage 6
  logic [NDS:0]       dv;
  meta_t              dmeta [NDS+1];
  logic [UW-1:0]      dden  [NDS+1];
  logic [UW-1:0]      drem  [NDS+1][NLANE];
  logic [QW-1:0]      dq    [NDS+1][NLANE];
  logic [NLANE-1:0]   dbig  [NDS+1];
  logic [NLANE-1:0]   dneg  [NDS+1];

  logic [SW-1:0]      adet;
  logic [SW-1:0]      ant;
  logic [AW-1:0]      aadj [3];

  assign adv          = !vout || rows.ready;
  assign matrix.ready = !fv || (adv && cnt == LAST_ROW);
  assign rows.valid   = vout;
  assign rows.data    = odata;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv  <= 1'b0;
      cnt <= FIRST_ROW;
    end else if (matrix.valid && matrix.ready) begin
      fv  <= 1'b1;
      cnt <= FIRST_ROW;
    end else if (adv && fv) begin
      if (cnt == LAST_ROW) begin
        fv <= 1'b0;
      end
      cnt <= cnt + row_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (matrix.valid && matrix.ready) begin
      rm[0][0] <= matrix.data.in_r0c0;
      rm[0][1] <= matrix.data.in_r0c1;
      rm[0][2] <= matrix.data.in_r0c2;
      rm[1][0] <= matrix.data.in_r1c0;
      rm[1][1] <= matrix.data.in_r1c1;
      rm[1][2] <= matrix.data.in_r1c2;
      rm[2][0] <= matrix.data.in_r2c0;
      rm[2][1] <= matrix.data.in_r2c1;
      rm[2][2] <= matrix.data.in_r2c2;
      tv[0]    <= matrix.data.in_r0c3;
      tv[1]    <= matrix.data.in_r1c3;
      tv[2]    <= matrix.data.in_r2c3;
    end else if (adv && fv) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          rm[r][c] <= rm[r][(c + 1) % 3];
        end
      end
    end
  end

  // valid bits of stages 1 to 5
  always_ff @(posedge clk) begin
    if (rst) begin
      s1v <= 1'b0;
      s2v <= 1'b0;
      s3v <= 1'b0;
      s4v <= 1'b0;
      s5v <= 1'b0;
    end else if (adv) begin
      s1v <= fv;
      s2v <= s1v;
      s3v <= s2v;
      s4v <= s3v;
      s5v <= s4v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1row <= cnt;
      s2row <= s1row;
      s3row <= s2row;
      s4row <= s3row;
      s5row <= s4row;
      for (int j = 0; j < 3; j++) begin
        // cofactor products of row i of the adjugate
        s1p[j]  <= rm[(j + 1) % 3][1] * rm[(j + 2) % 3][2];
        s1q[j]  <= rm[(j + 1) % 3][2] * rm[(j + 2) % 3][1];
        s1ca[j] <= rm[j][0];
        s1t[j]  <= tv[j];

        s2adj[j] <= $signed({s1p[j][PW-1], s1p[j]}) - $signed({s1q[j][PW-1], s1q[j]});
        s2ca[j]  <= s1ca[j];
        s2t[j]   <= s1t[j];

        s3adj[j] <= s2adj[j];
        s3dl[j]  <= $signed({1'b0, s2adj[j][DW-1:0]}) * s2ca[j];
        s3dh[j]  <= $signed(s2adj[j][AW-1:DW]) * s2ca[j];
        s3nl[j]  <= $signed({1'b0, s2adj[j][DW-1:0]}) * s2t[j];
        s3nh[j]  <= $signed(s2adj[j][AW-1:DW]) * s2t[j];

        s4adj[j] <= s3adj[j];
        s4dp[j]  <= (DETW'(s3dh[j]) <<< DW) + DETW'(s3dl[j]);
        s4np[j]  <= (DETW'(s3nh[j]) <<< DW) + DETW'(s3nl[j]);

        s5adj[j] <= s4adj[j];
      end
      // row i of adj times column i of A gives det
      s5det <= SW'(s4dp[0]) + SW'(s4dp[1]) + SW'(s4dp[2]);
      s5nt  <= -(SW'(s4np[0]) + SW'(s4np[1]) + SW'(s4np[2]));
    end
  end

  always_comb begin
    adet = s5det[SW-1] ? SW'(-s5det) : SW'(s5det);
    ant  = s5nt[SW-1] ? SW'(-s5nt) : SW'(s5nt);
    for (int j = 0; j < 3; j++) begin
      aadj[j] = s5adj[j][AW-1] ? AW'(-s5adj[j]) : AW'(s5adj[j]);
    end
  end

  // stage 6: magnitudes and signs into the divider
  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (adv) begin
      dv[0] <= s5v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dmeta[0].row  <= s5row;
      dmeta[0].sing <= (s5det == '0);
      dden[0]       <= UW'(adet);
      dbig[0]       <= '0;
      for (int j = 0; j < 3; j++) begin
        drem[0][j] <= UW'(aadj[j]) << (2 * FRAC_BITS);
        dq[0][j]   <= '0;
        dneg[0][j] <= s5adj[j][AW-1] ^ s5det[SW-1];
      end
      drem[0][3] <= UW'(ant) << FRAC_BITS;
      dq[0][3]   <= '0;
      dneg[0][3] <= s5nt[SW-1] ^ s5det[SW-1];
    end
  end

  // restoring divider: stage 0 flags quotients beyond QW bits,
  // each later stage settles one quotient bit, most significant first
  for (genvar s = 0; s < NDS; s++) begin : g_div
    localparam int SH = (s == 0) ? QW : QW - s;
    logic [UW-1:0] dsh;
    assign dsh = dden[s] << SH;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[s+1] <= 1'b0;
      end else if (adv) begin
        dv[s+1] <= dv[s];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dmeta[s+1] <= dmeta[s];
        dden[s+1]  <= dden[s];
        dneg[s+1]  <= dneg[s];
        for (int l = 0; l < NLANE; l++) begin
          if (s == 0) begin
            dbig[s+1][l] <= (drem[s][l] >= dsh);
            drem[s+1][l] <= drem[s][l];
            dq[s+1][l]   <= dq[s][l];
          end else begin
            dbig[s+1][l] <= dbig[s][l];
            if (drem[s][l] >= dsh) begin
              drem[s+1][l] <= drem[s][l] - dsh;
              dq[s+1][l]   <= {dq[s][l][QW-2:0], 1'b1};
            end else begin
              drem[s+1][l] <= drem[s][l];
              dq[s+1][l]   <= {dq[s][l][QW-2:0], 1'b0};
            end
          end
        end
      end
    end
  end

  // saturate and sign the quotients
  localparam logic [QW-1:0] LIM_NEG = QW'(1) << (DW - 1);
  localparam logic [QW-1:0] LIM_POS = LIM_NEG - QW'(1);

  logic [DW-1:0]    qval [NLANE];
  logic [NLANE-1:0] qsat;
  logic [QW-1:0]    qmag;

  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      qmag = dq[NDS][l];
      if (dneg[NDS][l]) begin
        qsat[l] = dbig[NDS][l] || (qmag > LIM_NEG);
        if (qsat[l]) begin
          qmag = LIM_NEG;
        end
        qval[l] = DW'(QW'(0) - qmag);
      end else begin
        qsat[l] = dbig[NDS][l] || (qmag > LIM_POS);
        if (qsat[l]) begin
          qmag = LIM_POS;
        end
        qval[l] = DW'(qmag);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (adv) begin
      vout <= dv[NDS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      odata.row_index <= dmeta[NDS].row;
      odata.singular  <= dmeta[NDS].sing;
      odata.last_row  <= (dmeta[NDS].row == LAST_ROW);
      if (dmeta[NDS].sing) begin
        odata.out_c0    <= '0;
        odata.out_c1    <= '0;
        odata.out_c2    <= '0;
        odata.out_c3    <= '0;
        odata.saturated <= 1'b0;
      end else begin
        odata.out_c0    <= qval[0];
        odata.out_c1    <= qval[1];
        odata.out_c2    <= qval[2];
        odata.out_c3    <= qval[3];
        odata.saturated <= |qsat;
      end
    end
  end

endmodule
